>>> rtl/core/mm_pkg.sv
package mm_pkg;

    localparam int MM_MAX_DIM   = 8;
    localparam int MM_IDX_W     = 3;
    localparam int MM_DIM_W     = 4;
    localparam int MM_VAL_W     = 16;
    localparam int MM_PROD_W    = 32;
    localparam int MM_ACC_W     = 36;
    localparam int MM_CFG_IDX_W = 2;
    localparam int MM_OP_W      = 2;
    localparam int MM_S_TDATA_W = 24;
    localparam int MM_M_TDATA_W = 48;

    typedef enum logic [MM_OP_W-1:0] {
        OP_WR_A    = 2'd0,
        OP_WR_B    = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } mm_op_t;

    typedef enum logic [MM_CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } mm_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_WAIT,
        ST_ISSUE,
        ST_DRAIN
    } mm_state_t;

    typedef struct packed {
        logic                wr_a;
        logic                wr_b;
        logic                rd_en;
        logic [MM_IDX_W-1:0] rd_i;
        logic [MM_IDX_W-1:0] rd_j;
        logic [MM_IDX_W-1:0] rd_k;
        logic                first_k;
        logic                last_k;
        logic                last_elem;
        logic                load_err;
    } mm_cmd_t;

    typedef struct packed {
        logic                dims_match;
        logic                out_full;
        logic [MM_DIM_W-1:0] n;
        logic [MM_DIM_W-1:0] m;
        logic [MM_DIM_W-1:0] q;
    } mm_stat_t;

endpackage

>>> rtl/core/mm_ram.sv
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mm_datapath.sv
module mm_datapath
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MM_MAX_DIM
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MM_CFG_IDX_W-1:0] cfg_index,
    input  logic [MM_DIM_W-1:0]     cfg_data,
    // row, col, value, zero pad
    input  logic [MM_S_TDATA_W-1:0] s_tdata,
    input  mm_cmd_t                 cmd,
    output mm_stat_t                stat,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_row, out_col, product, zero pad
    output logic [MM_M_TDATA_W-1:0] m_tdata,
    // dim_error
    output logic                    m_tuser,
    output logic                    m_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIN_W  = 2 * MM_IDX_W + 1;
    localparam logic [MM_DIM_W-1:0] DIM_MAX = MM_DIM_W'(MAX_DIM);

    function automatic logic [ADDR_W-1:0] lin_addr(input logic [MM_IDX_W-1:0] r,
                                                   input logic [MM_IDX_W-1:0] c);
        logic [LIN_W-1:0] full;
        full = LIN_W'(r) * LIN_W'(MAX_DIM) + LIN_W'(c);
        return full[ADDR_W-1:0];
    endfunction

    function automatic logic [MM_DIM_W-1:0] sat_dim(input logic [MM_DIM_W-1:0] d);
        logic [MM_DIM_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = MM_DIM_W'(1);
        end else if (d > DIM_MAX) begin
            res = DIM_MAX;
        end
        return res;
    endfunction

    logic [MM_DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

    logic [MM_IDX_W-1:0] in_row, in_col;
    logic [MM_VAL_W-1:0] in_value;
    logic                in_range;
    logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
    logic                a_we, b_we;
    logic [DEPTH-1:0]    a_vld_reg, b_vld_reg;
    logic [MM_VAL_W-1:0] a_rdata, b_rdata;

    logic                p1_vld_reg, p1_a_ok_reg, p1_b_ok_reg;
    logic                p1_first_reg, p1_last_k_reg, p1_last_elem_reg;
    logic [MM_IDX_W-1:0] p1_i_reg, p1_j_reg;

    logic signed [MM_VAL_W-1:0]  op_a, op_b;
    logic signed [MM_PROD_W-1:0] prod_next;

    logic                        p2_vld_reg, p2_first_reg, p2_last_k_reg, p2_last_elem_reg;
    logic [MM_IDX_W-1:0]         p2_i_reg, p2_j_reg;
    logic signed [MM_PROD_W-1:0] prod_reg;

    logic signed [MM_ACC_W-1:0] acc_reg, acc_base, sum_next;

    logic                m_tvalid_reg, m_err_reg, m_last_reg;
    logic [MM_IDX_W-1:0] m_row_reg, m_col_reg;
    logic [MM_ACC_W-1:0] m_prod_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg <= MM_DIM_W'(1);
            a_cols_reg <= MM_DIM_W'(1);
            b_rows_reg <= MM_DIM_W'(1);
            b_cols_reg <= MM_DIM_W'(1);
        end else if (cfg_valid) begin
            unique case (mm_cfg_t'(cfg_index))
                CFG_A_ROWS: a_rows_reg <= cfg_data;
                CFG_A_COLS: a_cols_reg <= cfg_data;
                CFG_B_ROWS: b_rows_reg <= cfg_data;
                CFG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign stat.n          = sat_dim(a_rows_reg);
    assign stat.m          = sat_dim(a_cols_reg);
    assign stat.q          = sat_dim(b_cols_reg);
    assign stat.dims_match = (sat_dim(a_cols_reg) == sat_dim(b_rows_reg));
    assign stat.out_full   = m_tvalid_reg;

    // element stores
    assign in_row   = s_tdata[MM_IDX_W-1:0];
    assign in_col   = s_tdata[2*MM_IDX_W-1:MM_IDX_W];
    assign in_value = s_tdata[2*MM_IDX_W+MM_VAL_W-1:2*MM_IDX_W];
    assign in_range = ({1'b0, in_row} < DIM_MAX) && ({1'b0, in_col} < DIM_MAX);
    assign wr_addr  = lin_addr(in_row, in_col);
    assign a_we     = cmd.wr_a && in_range;
    assign b_we     = cmd.wr_b && in_range;

    assign rd_addr_a = lin_addr(cmd.rd_i, cmd.rd_k);
    assign rd_addr_b = lin_addr(cmd.rd_k, cmd.rd_j);

    mm_ram #(
        .WIDTH (MM_VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr_a),
        .rdata (a_rdata)
    );

    mm_ram #(
        .WIDTH (MM_VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr_b),
        .rdata (b_rdata)
    );

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
        end else begin
            if (a_we) begin
                a_vld_reg[wr_addr] <= 1'b1;
            end
            if (b_we) begin
                b_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= cmd.rd_en;
        end
        p1_a_ok_reg      <= a_vld_reg[rd_addr_a];
        p1_b_ok_reg      <= b_vld_reg[rd_addr_b];
        p1_first_reg     <= cmd.first_k;
        p1_last_k_reg    <= cmd.last_k;
        p1_last_elem_reg <= cmd.last_elem;
        p1_i_reg         <= cmd.rd_i;
        p1_j_reg         <= cmd.rd_j;
    end

    // multiply stage
    assign op_a      = p1_a_ok_reg ? signed'(a_rdata) : '0;
    assign op_b      = p1_b_ok_reg ? signed'(b_rdata) : '0;
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else begin
            p2_vld_reg <= p1_vld_reg;
        end
        prod_reg         <= prod_next;
        p2_first_reg     <= p1_first_reg;
        p2_last_k_reg    <= p1_last_k_reg;
        p2_last_elem_reg <= p1_last_elem_reg;
        p2_i_reg         <= p1_i_reg;
        p2_j_reg         <= p1_j_reg;
    end

    // accumulate stage
    assign acc_base = p2_first_reg ? '0 : acc_reg;
    assign sum_next = acc_base + {{(MM_ACC_W-MM_PROD_W){prod_reg[MM_PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (p2_vld_reg) begin
            acc_reg <= sum_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_err) begin
            m_tvalid_reg <= 1'b1;
            m_row_reg    <= '0;
            m_col_reg    <= '0;
            m_prod_reg   <= '0;
            m_err_reg    <= 1'b1;
            m_last_reg   <= 1'b1;
        end else if (p2_vld_reg && p2_last_k_reg) begin
            m_tvalid_reg <= 1'b1;
            m_row_reg    <= p2_i_reg;
            m_col_reg    <= p2_j_reg;
            m_prod_reg   <= sum_next;
            m_err_reg    <= 1'b0;
            m_last_reg   <= p2_last_elem_reg;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(MM_M_TDATA_W-2*MM_IDX_W-MM_ACC_W){1'b0}},
                       m_prod_reg, m_col_reg, m_row_reg};
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/core/mm_ctrl.sv
module mm_ctrl
    import mm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // cmd
    input  logic [MM_OP_W-1:0] s_tuser,
    input  mm_stat_t           stat,
    output mm_cmd_t            cmd
);

    mm_state_t           state_reg, state_next;
    logic [MM_IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                k_last, j_last, elem_last;

    assign k_last    = ({1'b0, k_reg} + MM_DIM_W'(1)) == stat.m;
    assign j_last    = ({1'b0, j_reg} + MM_DIM_W'(1)) == stat.q;
    assign elem_last = j_last && (({1'b0, i_reg} + MM_DIM_W'(1)) == stat.n);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.rd_i      = i_reg;
        cmd.rd_j      = j_reg;
        cmd.rd_k      = k_reg;
        cmd.first_k   = (k_reg == '0);
        cmd.last_k    = k_last;
        cmd.last_elem = elem_last;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (mm_op_t'(s_tuser))
                        OP_WR_A: cmd.wr_a = 1'b1;
                        OP_WR_B: cmd.wr_b = 1'b1;
                        OP_COMPUTE: begin
                            i_next = '0;
                            j_next = '0;
                            state_next = stat.dims_match ? ST_WAIT : ST_ERR;
                        end
                        OP_NONE: ;
                        default: ;
                    endcase
                end
            end
            ST_ERR: begin
                if (!stat.out_full) begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (!stat.out_full) begin
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.rd_en = 1'b1;
                if (k_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + MM_IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // result has landed in the output register
                if (stat.out_full) begin
                    if (elem_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                        if (j_last) begin
                            j_next = '0;
                            i_next = i_reg + MM_IDX_W'(1);
                        end else begin
                            j_next = j_reg + MM_IDX_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_issue_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !stat.out_full)
        else $error("element read issued while a result is pending");

    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_err |-> !stat.out_full)
        else $error("error result loaded over a pending result");

    a_drain_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && stat.out_full) |=> state_reg != ST_DRAIN)
        else $error("drain did not advance after result landed");

    a_no_issue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE && k_last) |=> !cmd.rd_en)
        else $error("read issued past the inner dimension");
`endif

endmodule

>>> rtl/core/matrix_multiply.sv
// element load: one transfer per cycle while idle, no result
// compute: each result element passes the read, multiply and accumulate stages into
// the output register, a_rows * b_cols elements per run, each held while the sink stalls
// dimension mismatch: single error result, loaded once the output register is free
// reset: synchronous active-low, dimensions to 1, both stores read as zero at once
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MM_MAX_DIM
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MM_CFG_IDX_W-1:0] cfg_index,
    input  logic [MM_DIM_W-1:0]     cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // row, col, value, zero pad
    input  logic [MM_S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [MM_OP_W-1:0]      s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_row, out_col, product, zero pad
    output logic [MM_M_TDATA_W-1:0] m_tdata,
    // dim_error
    output logic                    m_tuser,
    output logic                    m_tlast
);

    mm_cmd_t  cmd;
    mm_stat_t stat;

    mm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    mm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
